// File: rtl/core/fpars_pkg.sv
`timescale 1ns / 1ps

package fpars_pkg;

	localparam int DEPTH_DEF = 1024;
	localparam int IDX_W     = 11;
	localparam int WALK_W    = IDX_W + 1;
	localparam int DELTA_W   = 32;
	localparam int SUM_W     = 64;

	localparam logic [IDX_W-1:0] SIZE_RESET = 11'd1024;

	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

endpackage

// File: rtl/core/fenwick_point_add_range_sum.sv
`timescale 1ns / 1ps

// binary indexed tree with point add and range sum
// requests arrive on in_valid/in_ready: func selects an add of delta at
// first_index (no result) or a sum over first_index..last_index (one result
// on out_valid/out_ready). size_in_use is written on cfg_valid/cfg_ready and
// is always ready; write it only while the block is idle.
// one request at a time: in_ready is high only in the idle state.
// an add holds the block while it walks the update path of first_index,
// reading each node and writing it back with delta added; a sum holds it
// while it walks the prefix path of last_index and then that of
// first_index - 1, subtracting the second, and writes its result to the
// output register. the block then returns to the idle state, where it takes
// the next request. the single memory port pair (one read, one write per
// cycle) and the one shared 64-bit adder set the pace of these walks.
// after reset all min(DEPTH, 2047) entries of the tree memory are zeroed,
// one entry per cycle; in_ready stays low during that pass.
// a finished sum sits in an output register, so a new request is taken while
// it waits; a stalled receiver holds back only the completion of the next sum.

module fenwick_point_add_range_sum #(
	parameter int DEPTH = fpars_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               func,
	input  logic [fpars_pkg::IDX_W-1:0]        first_index,
	input  logic [fpars_pkg::IDX_W-1:0]        last_index,
	input  logic signed [fpars_pkg::DELTA_W-1:0] delta,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [fpars_pkg::SUM_W-1:0] range_sum,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fpars_pkg::IDX_W-1:0]        size_in_use
);

	localparam int IW = fpars_pkg::IDX_W;
	localparam int WW = fpars_pkg::WALK_W;
	localparam int DW = fpars_pkg::DELTA_W;
	localparam int SW = fpars_pkg::SUM_W;
	localparam int MAX_POS = (1 << IW) - 1;
	localparam int MEM_DEPTH = (DEPTH > MAX_POS) ? MAX_POS : DEPTH;
	localparam int AW = $clog2(MEM_DEPTH);
	localparam logic [IW-1:0] N_MAX = IW'(MEM_DEPTH);
	localparam logic [AW-1:0] CLR_LAST = AW'(MEM_DEPTH - 1);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_ADD   = 4'b0100,
		ST_QUERY = 4'b1000
	} state_t;

	state_t          state_q;
	logic [IW-1:0]   size_q;
	logic [AW-1:0]   clr_q;
	logic            pend_q;
	logic            phase_q;
	logic            out_valid_q;

	logic [WW-1:0]   i_q;
	logic [IW-1:0]   lo_q;
	logic            pend_sub_q;
	logic [AW-1:0]   waddr_q;
	logic [DW-1:0]   delta_q;
	logic [SW-1:0]   acc_q;
	logic [SW-1:0]   out_sum_q;

	logic [IW-1:0]   n;
	logic [IW-1:0]   lo_raw;
	logic [IW-1:0]   lo_in;
	logic [IW-1:0]   hi_in;
	logic [WW-1:0]   low_bit;
	logic            i_live;
	logic            out_free;
	logic            sum_done;

	logic [SW-1:0]   op_a;
	logic [SW-1:0]   op_b;
	logic            op_sub;
	logic [SW-1:0]   sum;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [SW-1:0]   ram_wdata;
	logic [AW-1:0]   ram_raddr;
	logic [SW-1:0]   ram_rdata;

	fpars_ram #(
		.WIDTH (SW),
		.DEPTH (MEM_DEPTH)
	) u_tree (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign n = (size_q < N_MAX) ? size_q : N_MAX;

	assign lo_raw = (first_index == '0) ? '0 : first_index - IW'(1);
	assign lo_in  = (lo_raw > n) ? n : lo_raw;
	assign hi_in  = (last_index < n) ? last_index : n;

	assign low_bit  = i_q & (~i_q + WW'(1));
	assign i_live   = (i_q != '0) && (i_q <= {1'b0, n});
	assign out_free = !out_valid_q || out_ready;
	assign sum_done = (state_q == ST_QUERY) && (i_q == '0) && phase_q && !pend_q && out_free;

	// shared adder: tree update on adds, signed accumulate on sums
	always_comb begin
		if (state_q == ST_ADD) begin
			op_a   = ram_rdata;
			op_b   = {{(SW - DW){delta_q[DW-1]}}, delta_q};
			op_sub = 1'b0;
		end else begin
			op_a   = acc_q;
			op_b   = ram_rdata;
			op_sub = pend_sub_q;
		end
		sum = op_a + (op_b ^ {SW{op_sub}}) + SW'(op_sub);
	end

	assign ram_we    = (state_q == ST_CLEAR) || ((state_q == ST_ADD) && pend_q);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : waddr_q;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : sum;
	assign ram_raddr = AW'(i_q - WW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			size_q      <= fpars_pkg::SIZE_RESET;
			clr_q       <= '0;
			pend_q      <= 1'b0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				size_q <= size_in_use;
			end
			if (sum_done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					pend_q  <= 1'b0;
					phase_q <= 1'b0;
					if (in_valid) begin
						state_q <= (func == fpars_pkg::FUNC_ADD) ? ST_ADD : ST_QUERY;
					end
				end
				ST_ADD: begin
					if (i_live) begin
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_QUERY: begin
					if (i_q != '0) begin
						pend_q <= 1'b1;
					end else if (!phase_q) begin
						phase_q <= 1'b1;
						pend_q  <= 1'b0;
					end else if (pend_q) begin
						pend_q <= 1'b0;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				acc_q <= '0;
				if (func == fpars_pkg::FUNC_ADD) begin
					i_q <= {1'b0, first_index};
				end else begin
					i_q <= {1'b0, hi_in};
				end
				lo_q    <= lo_in;
				delta_q <= delta;
			end
			ST_ADD: begin
				if (i_live) begin
					waddr_q <= ram_raddr;
					i_q     <= i_q + low_bit;
				end
			end
			ST_QUERY: begin
				if (pend_q) begin
					acc_q <= sum;
				end
				if (i_q != '0) begin
					pend_sub_q <= phase_q;
					i_q        <= i_q & (i_q - WW'(1));
				end else if (!phase_q) begin
					i_q <= {1'b0, lo_q};
				end else if (!pend_q && out_free) begin
					out_sum_q <= acc_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign range_sum = out_sum_q;

endmodule

// File: rtl/core/fpars_ram.sv
`timescale 1ns / 1ps

module fpars_ram #(
	parameter int WIDTH = fpars_pkg::SUM_W,
	parameter int DEPTH = fpars_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
